// ===== hdl/nsfc_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence framer/checker package
// Shared constants, codes, the prefix table and the result beat layout.
// ---------------------------------------------------------------------------
`default_nettype none

package nsfc_pkg;

    // Line buffer size; a line holds at most LINE_BUF_SIZE-1 bytes
    localparam int LINE_BUF_SIZE = 256;
    localparam logic [7:0] LINE_MAX = 8'(LINE_BUF_SIZE - 1);

    // Minimum length of a line that can carry a checksum
    localparam logic [7:0] MIN_LINE_LEN = 8'd8;
    localparam int PREFIX_LEN = 6;
    localparam int PREFIX_COUNT = 8;

    // Characters of interest
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    // Beat widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 30;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NO_STAR  = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_OVERFLOW = 3'd4
    } line_status_t;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GGA   = 3'd1,
        KIND_VTG   = 3'd2,
        KIND_GSA   = 3'd3,
        KIND_RMC   = 3'd4
    } sentence_kind_t;

    // One verdict
    typedef struct packed {
        logic [7:0]     given_sum;
        logic [7:0]     computed_sum;
        logic [7:0]     line_length;
        sentence_kind_t sentence_kind;
        line_status_t   line_status;
    } line_result_t;

    // Prefix table: entry 2k is the GN talker, 2k+1 the GP talker;
    // k runs over GGA, VTG, GSA, RMC
    localparam logic [7:0] PREFIX_TABLE [PREFIX_COUNT][PREFIX_LEN] = '{
        '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41},
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
        '{8'h24, 8'h47, 8'h4E, 8'h56, 8'h54, 8'h47},
        '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47},
        '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h53, 8'h41},
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
        '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},
        '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43}
    };

endpackage

`default_nettype wire

// ===== hdl/nmea_sentence_framer_checker.sv =====
// ---------------------------------------------------------------------------
// NMEA 0183 sentence framer and checksum checker
// Takes one received byte per beat and gives one verdict beat per line.
// ---------------------------------------------------------------------------
// Throughput is one byte per clock cycle unless a verdict is held back by a
// stalled output: each byte is captured in an input register, folded into
// the line state by a single level of logic and, when it ends a line
// (CR/LF after a non-empty line) or overflows it, the verdict is formed from
// the input register and loaded into the output register. The input keeps
// taking bytes while a verdict waits in the output register; only a second
// verdict behind a stalled one holds the input. Verdict beat: status, kind,
// length, XOR sum of the body and the hex sum given after the star.
`default_nettype none

module nmea_sentence_framer_checker
    import nsfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_TDATA_W-1:0]     m_tdata    // [2:0] line_status,
                                                  // [5:3] sentence_kind,
                                                  // [13:6] line_length,
                                                  // [21:14] computed_sum,
                                                  // [29:22] given_sum
);

    logic         byte_valid_reg, byte_valid_next;
    logic [7:0]   byte_reg;
    logic         res_valid;
    line_result_t result;
    logic         can_load;
    logic         stage_go;
    logic         out_load;

    // Stage advances unless it has a verdict and the output slot is busy
    assign stage_go = byte_valid_reg && (!res_valid || can_load);
    assign out_load = stage_go && res_valid;
    assign s_tready = !byte_valid_reg || stage_go;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (s_tready)
        begin
            byte_valid_next = s_tvalid;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    nsfc_line_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (byte_reg),
        .go        (stage_go),
        .res_valid (res_valid),
        .result    (result)
    );

    nsfc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // a verdict that leaves the stage shows up on the master side
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("verdict lost after load");

    // a held byte with a blocked verdict stays put
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid_reg && !stage_go |=> byte_valid_reg && $stable(byte_reg))
        else $error("stalled byte changed");

    // only accepted lines carry a sentence kind
    a_kind_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && result.line_status != ST_ACCEPTED |->
        result.sentence_kind == KIND_OTHER)
        else $error("kind on rejected line");

    // overflow always reports a full line
    a_overflow_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && result.line_status == ST_OVERFLOW |->
        result.line_length == LINE_MAX)
        else $error("overflow length wrong");
`endif

endmodule

`default_nettype wire

// ===== hdl/nsfc_line_track.sv =====
// ---------------------------------------------------------------------------
// NMEA line tracker
// Holds the per-line state, folds one byte in per go strobe and forms the
// verdict when a terminator ends a line or the line overflows.
// ---------------------------------------------------------------------------
`default_nettype none

module nsfc_line_track
    import nsfc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         go,
    output logic              res_valid,
    output line_result_t      result
);

    logic [7:0] line_count_reg,      line_count_next;
    logic [7:0] xor_acc_reg,         xor_acc_next;
    logic       star_found_reg,      star_found_next;
    logic [7:0] star_pos_reg,        star_pos_next;
    logic       dollar_reg,          dollar_next;
    logic [7:0] hex_value_reg,       hex_value_next;
    logic [1:0] hex_seen_reg,        hex_seen_next;
    logic       hex_ended_reg,       hex_ended_next;
    logic [7:0] prefix_match_reg,    prefix_match_next;

    logic       is_term;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] len_minus3;

    // Hex digit decode
    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
        begin
            hex_val = 4'(rx_byte - 8'h30);
        end
        else if (rx_byte >= 8'h61 && rx_byte <= 8'h66)
        begin
            hex_val = 4'(rx_byte - 8'h57);
        end
        else if (rx_byte >= 8'h41 && rx_byte <= 8'h46)
        begin
            hex_val = 4'(rx_byte - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign is_term    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign len_minus3 = line_count_reg - 8'd3;

    // Verdict
    always_comb
    begin
        res_valid            = 1'b0;
        result.line_status   = ST_ACCEPTED;
        result.sentence_kind = KIND_OTHER;
        result.line_length   = line_count_reg;
        result.computed_sum  = 8'd0;
        result.given_sum     = 8'd0;
        if (is_term)
        begin
            res_valid = (line_count_reg != 8'd0);
            if (line_count_reg < MIN_LINE_LEN || !dollar_reg)
            begin
                result.line_status = ST_SHORT;
            end
            else if (!star_found_reg || star_pos_reg > len_minus3)
            begin
                result.line_status = ST_NO_STAR;
            end
            else
            begin
                result.computed_sum = xor_acc_reg;
                result.given_sum    = hex_value_reg;
                if (xor_acc_reg != hex_value_reg)
                begin
                    result.line_status = ST_MISMATCH;
                end
                else if (prefix_match_reg[0] || prefix_match_reg[1])
                begin
                    result.sentence_kind = KIND_GGA;
                end
                else if (prefix_match_reg[2] || prefix_match_reg[3])
                begin
                    result.sentence_kind = KIND_VTG;
                end
                else if (prefix_match_reg[4] || prefix_match_reg[5])
                begin
                    result.sentence_kind = KIND_GSA;
                end
                else if (prefix_match_reg[6] || prefix_match_reg[7])
                begin
                    result.sentence_kind = KIND_RMC;
                end
            end
        end
        else if (line_count_reg >= LINE_MAX)
        begin
            res_valid          = 1'b1;
            result.line_status = ST_OVERFLOW;
        end
    end

    // Next line state
    always_comb
    begin
        line_count_next   = line_count_reg;
        xor_acc_next      = xor_acc_reg;
        star_found_next   = star_found_reg;
        star_pos_next     = star_pos_reg;
        dollar_next       = dollar_reg;
        hex_value_next    = hex_value_reg;
        hex_seen_next     = hex_seen_reg;
        hex_ended_next    = hex_ended_reg;
        prefix_match_next = prefix_match_reg;
        if (res_valid)
        begin
            // line done: back to the empty line
            line_count_next   = 8'd0;
            xor_acc_next      = 8'd0;
            star_found_next   = 1'b0;
            star_pos_next     = 8'd0;
            dollar_next       = 1'b0;
            hex_value_next    = 8'd0;
            hex_seen_next     = 2'd0;
            hex_ended_next    = 1'b0;
            prefix_match_next = '1;
        end
        else if (!is_term)
        begin
            if (line_count_reg == 8'd0)
            begin
                dollar_next = (rx_byte == CHAR_DOLLAR);
            end
            if (line_count_reg < 8'(PREFIX_LEN))
            begin
                for (int k = 0; k < PREFIX_COUNT; k++)
                begin
                    if (PREFIX_TABLE[k][line_count_reg[2:0]] != rx_byte)
                    begin
                        prefix_match_next[k] = 1'b0;
                    end
                end
            end
            if (star_found_reg)
            begin
                if (!hex_ended_reg && hex_seen_reg < 2'd2)
                begin
                    if (!is_hex)
                    begin
                        hex_ended_next = 1'b1;
                    end
                    else
                    begin
                        hex_value_next = {hex_value_reg[3:0], hex_val};
                        hex_seen_next  = hex_seen_reg + 2'd1;
                    end
                end
            end
            else if (line_count_reg != 8'd0)
            begin
                if (rx_byte == CHAR_STAR)
                begin
                    star_found_next = 1'b1;
                    star_pos_next   = line_count_reg;
                end
                else
                begin
                    xor_acc_next = xor_acc_reg ^ rx_byte;
                end
            end
            line_count_next = line_count_reg + 8'd1;
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg   <= 8'd0;
            xor_acc_reg      <= 8'd0;
            star_found_reg   <= 1'b0;
            star_pos_reg     <= 8'd0;
            dollar_reg       <= 1'b0;
            hex_value_reg    <= 8'd0;
            hex_seen_reg     <= 2'd0;
            hex_ended_reg    <= 1'b0;
            prefix_match_reg <= '1;
        end
        else if (go)
        begin
            line_count_reg   <= line_count_next;
            xor_acc_reg      <= xor_acc_next;
            star_found_reg   <= star_found_next;
            star_pos_reg     <= star_pos_next;
            dollar_reg       <= dollar_next;
            hex_value_reg    <= hex_value_next;
            hex_seen_reg     <= hex_seen_next;
            hex_ended_reg    <= hex_ended_next;
            prefix_match_reg <= prefix_match_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nsfc_out_reg.sv =====
// ---------------------------------------------------------------------------
// NMEA verdict output register
// Holds one result beat for the master side and reports when it can load.
// ---------------------------------------------------------------------------
`default_nettype none

module nsfc_out_reg
    import nsfc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire line_result_t             result,
    output logic                          can_load,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]        m_tdata
);

    logic         valid_reg, valid_next;
    line_result_t data_reg;

    // slot frees up when empty or when the held beat is taken
    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, data_reg};

endmodule

`default_nettype wire
